@@ rtl/pst_pkg.sv @@
// Package with shared types and constants for the process slot table.
`timescale 1ns / 1ps
`default_nettype none
package pst_pkg;
   localparam int SlotCount = 16;

   localparam logic [1:0] OP_SPAWN = 2'd0;
   localparam logic [1:0] OP_EXIT  = 2'd1;
   localparam logic [1:0] OP_WAIT  = 2'd2;
   localparam logic [1:0] OP_FIND  = 2'd3;

   localparam logic [2:0] ST_OK       = 3'd0;
   localparam logic [2:0] ST_INVAL    = 3'd1;
   localparam logic [2:0] ST_NOTFOUND = 3'd2;
   localparam logic [2:0] ST_FULL     = 3'd3;
   localparam logic [2:0] ST_NOCHILD  = 3'd4;

   typedef struct packed {
      logic        used;
      logic [30:0] pid;
      logic [30:0] parent;
      logic        exited;
      logic [31:0] code;
   } slot_type;

   // Command broadcast to every cell; the match token passed down the row is separate.
   typedef struct packed {
      logic        scan;     // compare this cycle
      logic        repar;    // hand children of tpid to the reaper this cycle
      logic [1:0]  op;
      logic [31:0] tpid;
      logic [30:0] ppid;
      logic [31:0] code;
      logic [30:0] reaper;
      logic [30:0] new_pid;
      logic        any;
   } cmd_type;
endpackage
`default_nettype wire

@@ rtl/pst_cell.sv @@
// One slot of the table; passes a claim token to its neighbor.
`timescale 1ns / 1ps
`default_nettype none
module pst_cell (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire pst_pkg::slot_type reset_val,
   input  wire pst_pkg::cmd_type cmd,
   input  wire logic             token_in,  // an earlier slot already matched
   output logic                  token_out,
   output logic                  hit,
   output pst_pkg::slot_type     slot
);
   import pst_pkg::*;
   slot_type slot_ff, slot_in;
   logic     match;

   always_comb begin
      match = 1'b0;
      unique case (cmd.op)
         OP_SPAWN: match = !slot_ff.used;
         OP_EXIT, OP_FIND:
            match = slot_ff.used && ({1'b0, slot_ff.pid} == cmd.tpid);
         OP_WAIT: match = slot_ff.used && slot_ff.parent == cmd.ppid && slot_ff.exited
                          && (cmd.any || {1'b0, slot_ff.pid} == cmd.tpid);
         default: match = 1'b0;
      endcase
      hit = cmd.scan && match && !token_in;
      token_out = token_in || (cmd.scan && match);
      slot_in = slot_ff;
      if (hit) begin
         case (cmd.op)
            OP_SPAWN: begin
               slot_in.used = 1'b1;
               slot_in.pid = cmd.new_pid;
               slot_in.parent = cmd.ppid;
               slot_in.exited = 1'b1;
               slot_in.code = cmd.code;
            end
            OP_EXIT: begin
               slot_in.exited = 1'b1;
               slot_in.code = cmd.code;
            end
            OP_WAIT: slot_in = '0;
            default: ;
         endcase
      end
      // A used slot whose parent just exited is handed to the reaper.
      if (cmd.repar && slot_ff.used && {1'b0, slot_ff.parent} == cmd.tpid) begin
         slot_in.parent = cmd.reaper;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) slot_ff <= reset_val;
      else slot_ff <= slot_in;
   end
   assign slot = slot_ff;
endmodule
`default_nettype wire

@@ rtl/process_slot_table.sv @@
// Top level of the process slot table: a row of slot cells and a sequencer.
//
// Usage: drive req_* with start high while busy is low; the command beat is
// taken at that edge. In the first cycle after the accept, the claim token
// ripples down the row of slot cells, each cell comparing its own slot and
// handing the token on, so the first matching slot wins and updates itself.
// Mark exited then passes through a reparent step in which, if the pid was
// found, every used cell whose parent equals the pid takes the reaper as new
// parent. In the next cycle the result beat appears on rsp_* with rsp_valid
// high for exactly one cycle; the receiver cannot hold it off. Busy falls
// once the result beat is gone, and only then can the next command be taken;
// a new command is not accepted while the scan, reparent and output steps of
// the last one are still running.
// Reset (synchronous) loads slot 0 with pid 1, clears the other slots, and
// sets the next pid to 2; busy is low right after reset.
`timescale 1ns / 1ps
`default_nettype none
module process_slot_table (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   output logic             busy,
   input  wire logic [1:0]  req_operation,
   input  wire logic [31:0] req_target_pid,
   input  wire logic [30:0] req_parent_pid,
   input  wire logic [31:0] req_exit_code,
   input  wire logic [30:0] req_reaper_pid,
   output logic             rsp_valid,
   output logic [2:0]       rsp_status,
   output logic [30:0]      rsp_result_pid,
   output logic [31:0]      rsp_wait_status,
   output logic [30:0]      rsp_found_parent,
   output logic             rsp_found_exited,
   output logic [31:0]      rsp_found_code
);
   import pst_pkg::*;

   typedef enum logic [3:0] {
      S_IDLE = 4'b0001, S_SCAN = 4'b0010, S_REPAR = 4'b0100, S_DONE = 4'b1000
   } state_type;

   state_type   state_ff, state_in;
   cmd_type     cmd_ff;
   cmd_type     cmd_cell;
   logic [31:0] pid_next_ff;
   logic [31:0] spawn_count_ff;
   logic [2:0]  status_ff;
   slot_type    hit_slot_ff;
   logic        found_ff;
   logic [SlotCount:0] token;
   logic [SlotCount-1:0] hits;
   slot_type    slots [SlotCount];
   slot_type    sel;
   logic        pre_ok;

   // Argument checks that need no scan.
   always_comb begin
      pre_ok = 1'b1;
      unique case (cmd_ff.op)
         OP_SPAWN: pre_ok = cmd_ff.ppid != '0 && pid_next_ff != '0 && !pid_next_ff[31];
         OP_EXIT:  pre_ok = cmd_ff.tpid != '0 && cmd_ff.reaper != '0;
         OP_WAIT:  pre_ok = cmd_ff.ppid != '0;
         OP_FIND:  pre_ok = 1'b1;
         default:  pre_ok = 1'b1;
      endcase
   end

   always_comb begin
      cmd_cell = cmd_ff;
      cmd_cell.scan = (state_ff == S_SCAN) && pre_ok;
      cmd_cell.repar = (state_ff == S_REPAR) && found_ff;
      cmd_cell.new_pid = pid_next_ff[30:0];
   end

   assign token[0] = 1'b0;
   genvar g;
   generate
      for (g = 0; g < SlotCount; g++) begin : g_cell
         slot_type rv;
         always_comb begin
            rv = '0;
            if (g == 0) begin
               rv.used = 1'b1;
               rv.pid = 31'd1;
            end
         end
         slot_type cur;
         pst_cell u_cell (
            .clock, .reset, .reset_val(rv), .cmd(cmd_cell),
            .token_in(token[g]), .token_out(token[g+1]), .hit(hits[g]), .slot(cur)
         );
         assign slots[g] = cur;
      end
   endgenerate

   // Reparenting runs in the cycle after the scan, through the same cell
   // command, and only when the marked pid was found.

   always_comb begin
      sel = '0;
      for (int k = 0; k < SlotCount; k++) begin
         if (hits[k]) sel = slots[k];
      end
      if (cmd_ff.op == OP_SPAWN) sel.pid = pid_next_ff[30:0];
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE:  if (start) state_in = S_SCAN;
         S_SCAN:  state_in = (cmd_ff.op == OP_EXIT) ? S_REPAR : S_DONE;
         S_REPAR: state_in = S_DONE;
         S_DONE:  state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         pid_next_ff <= 32'd2;
         spawn_count_ff <= '0;
         cmd_ff.scan <= 1'b0;
         cmd_ff.repar <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (state_ff == S_IDLE && start) begin
            cmd_ff.scan <= 1'b0;
            cmd_ff.repar <= 1'b0;
            cmd_ff.op <= req_operation;
            cmd_ff.tpid <= req_target_pid;
            cmd_ff.ppid <= req_parent_pid;
            cmd_ff.code <= req_exit_code;
            cmd_ff.reaper <= req_reaper_pid;
            cmd_ff.new_pid <= '0;
            cmd_ff.any <= (req_target_pid == '0) || req_target_pid[31];
         end
         if (state_ff == S_SCAN && pre_ok && cmd_ff.op == OP_SPAWN && token[SlotCount]) begin
            pid_next_ff <= pid_next_ff + 32'd1;
            spawn_count_ff <= spawn_count_ff + 32'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == S_SCAN) begin
         hit_slot_ff <= sel;
         found_ff <= token[SlotCount];
         if (!pre_ok) begin
            // A spawn with a valid parent only fails here when pids ran out.
            if (cmd_ff.op == OP_SPAWN && cmd_ff.ppid != '0) status_ff <= ST_FULL;
            else status_ff <= ST_INVAL;
         end
         else if (token[SlotCount]) status_ff <= ST_OK;
         else begin
            case (cmd_ff.op)
               OP_SPAWN: status_ff <= ST_FULL;
               OP_WAIT:  status_ff <= ST_NOCHILD;
               default:  status_ff <= ST_NOTFOUND;
            endcase
         end
      end
   end

   assign busy = (state_ff != S_IDLE);
   assign rsp_valid = (state_ff == S_DONE);

   always_comb begin
      rsp_status = status_ff;
      rsp_result_pid = '0;
      rsp_wait_status = '0;
      rsp_found_parent = '0;
      rsp_found_exited = 1'b0;
      rsp_found_code = '0;
      if (status_ff == ST_OK) begin
         case (cmd_ff.op)
            OP_SPAWN: rsp_result_pid = hit_slot_ff.pid;
            OP_EXIT:  rsp_result_pid = cmd_ff.tpid[30:0];
            OP_WAIT: begin
               rsp_result_pid = hit_slot_ff.pid;
               rsp_wait_status = {hit_slot_ff.code[23:0], 8'd0};
            end
            default: begin
               rsp_result_pid = hit_slot_ff.pid;
               rsp_found_parent = hit_slot_ff.parent;
               rsp_found_exited = hit_slot_ff.exited;
               rsp_found_code = hit_slot_ff.code;
            end
         endcase
      end
   end
endmodule
`default_nettype wire
